// ===== hw/rtl/fixed_step_ray_march_wall_hit_macros.svh =====
// ----------------------------------------------------------------------------
// fixed step ray march wall hit - assertion macros
// concurrent check wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef FIXED_STEP_RAY_MARCH_WALL_HIT_MACROS_SVH
`define FIXED_STEP_RAY_MARCH_WALL_HIT_MACROS_SVH

`ifndef SYNTH

// plain property check, disabled during reset
`define FSRM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("fsrm assertion failed");

// same-cycle implication
`define FSRM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fsrm implication failed");

// next-cycle implication
`define FSRM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fsrm next-cycle implication failed");

`else

`define FSRM_ASSERT(lbl, clk, rstn, prop)
`define FSRM_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define FSRM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== hw/rtl/fsrm_pkg.sv =====
// ----------------------------------------------------------------------------
// fsrm_pkg
// shared types, widths and constants of the fixed step ray marcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fsrm_pkg;

    // map geometry defaults
    localparam int MAP_WIDTH_DEF  = 64;
    localparam int MAP_HEIGHT_DEF = 64;

    // field widths
    localparam int IDX_W   = 6;   // tile column / row
    localparam int TILE_W  = 8;   // tile type
    localparam int POS_W   = 22;  // q6.16 origin
    localparam int DIR_W   = 16;  // signed q1.14 direction
    localparam int STEP_W  = 16;  // q0.16 step
    localparam int LIM_W   = 21;  // q5.16 limit
    localparam int DIST_W  = 22;  // q6.16 march distance, room for one overshoot
    localparam int U_W     = 17;  // texture coordinate, 0..65536
    localparam int FRAC_W  = 16;
    localparam int COORD_W = 24;  // signed q8.16 test coordinate
    localparam int CELL_W  = COORD_W - FRAC_W;
    localparam int DSTEP_W = DIR_W + STEP_W + 1;   // dir * step
    localparam int PROD_W  = 38;                   // dir * d, exact q.30
    localparam int DIR_SH  = 14;                   // q.30 -> q.16
    localparam int ADDR_CALC_W = 2 * IDX_W + 1;

    // register reset values
    localparam logic [STEP_W-1:0] STEP_SIZE_RST = 16'd492;
    localparam logic [LIM_W-1:0]  MAX_DIST_RST  = 21'd1966080;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef enum logic [0:0] {
        REG_STEP_SIZE = 1'b0,
        REG_MAX_DIST  = 1'b1
    } reg_idx_t;

    typedef enum logic [0:0] {
        CMD_WRITE = 1'b0,
        CMD_CAST  = 1'b1
    } item_cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_INIT,
        ST_STEP,
        ST_PROBE,
        ST_DONE_WRITE,
        ST_DONE_HIT,
        ST_DONE_MISS
    } state_t;

    typedef enum logic [1:0] {
        RES_WRITE,
        RES_HIT,
        RES_MISS
    } res_kind_t;

    // controller -> datapath
    typedef struct packed {
        logic      clear_en;
        logic      capture_en;
        logic      write_en;
        logic      init_en;
        logic      step_en;
        logic      probe_en;
        logic      load_out;
        res_kind_t kind;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic wall;
        logic at_limit;
    } dp_status_t;

endpackage

// ===== hw/rtl/fixed_step_ray_march_wall_hit.sv =====
// ----------------------------------------------------------------------------
// fixed_step_ray_march_wall_hit
// tile write: captured, written to the map, result loaded before the next item
// ray cast: each march step is a step add, then a map read; one item in flight at
//   a time, the map read port sets the pace
// reset: synchronous, active low; the map is swept to zero, one tile per cycle,
//   all MAP_WIDTH*MAP_HEIGHT tiles (4096 by default), before the first item is taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_step_ray_march_wall_hit
    import fsrm_pkg::*;
#(
    parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = MAP_HEIGHT_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,

    // input items
    input  logic              s_tvalid,
    output logic              s_tready,
    // tile_col[5:0], tile_row[11:6], tile_value[19:12], origin_x[41:20],
    // origin_y[63:42], dir_x[79:64], dir_y[95:80]
    input  logic [95:0]       s_tdata,
    // cmd[0]: 0 tile write, 1 ray cast
    input  logic [0:0]        s_tuser,

    // results
    output logic              m_tvalid,
    input  logic              m_tready,
    // hit[0], distance[22:1], hit_col[28:23], hit_row[34:29], wall_type[42:35],
    // vertical_side[43], wall_u[60:44], zero[63:61]
    output logic [63:0]       m_tdata,
    // write_done[0]
    output logic [0:0]        m_tuser,

    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // configuration registers
    logic [STEP_W-1:0] step_size_reg;
    logic [LIM_W-1:0]  max_dist_reg;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    // controller <-> datapath
    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // unpacked result fields
    logic              res_hit;
    logic [DIST_W-1:0] res_distance;
    logic [IDX_W-1:0]  res_col;
    logic [IDX_W-1:0]  res_row;
    logic [TILE_W-1:0] res_type;
    logic              res_vert;
    logic [U_W-1:0]    res_u;
    logic              res_write_done;

    // register index is the word address
    assign cfg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg <= STEP_SIZE_RST;
            max_dist_reg  <= MAX_DIST_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_STEP_SIZE: step_size_reg <= pwdata[STEP_W-1:0];
                REG_MAX_DIST:  max_dist_reg  <= pwdata[LIM_W-1:0];
                default:       step_size_reg <= step_size_reg;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_STEP_SIZE: prdata = {{(APB_DW-STEP_W){1'b0}}, step_size_reg};
            REG_MAX_DIST:  prdata = {{(APB_DW-LIM_W){1'b0}}, max_dist_reg};
            default:       prdata = '0;
        endcase
    end

    // sequencer: owns the handshakes, steers the datapath
    fsrm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (item_cmd_t'(s_tuser[0])),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (dp_cmd),
        .status   (dp_status)
    );

    // map, accumulators and the result register
    fsrm_dp #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (dp_cmd),
        .status        (dp_status),
        .step_size     (step_size_reg),
        .max_distance  (max_dist_reg),
        .tile_col      (s_tdata[5:0]),
        .tile_row      (s_tdata[11:6]),
        .tile_value    (s_tdata[19:12]),
        .origin_x      (s_tdata[41:20]),
        .origin_y      (s_tdata[63:42]),
        .dir_x         ($signed(s_tdata[79:64])),
        .dir_y         ($signed(s_tdata[95:80])),
        .hit           (res_hit),
        .distance      (res_distance),
        .hit_col       (res_col),
        .hit_row       (res_row),
        .wall_type     (res_type),
        .vertical_side (res_vert),
        .wall_u        (res_u),
        .write_done    (res_write_done)
    );

    // pack the result transaction, padded to whole bytes
    assign m_tdata = {3'b000, res_u, res_vert, res_type, res_row, res_col,
                      res_distance, res_hit};
    assign m_tuser = res_write_done;

endmodule

// ===== hw/rtl/fsrm_dp.sv =====
// ----------------------------------------------------------------------------
// fsrm_dp
// march datapath: tile map, distance and offset accumulators, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fixed_step_ray_march_wall_hit_macros.svh"

module fsrm_dp
    import fsrm_pkg::*;
#(
    parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = MAP_HEIGHT_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    input  logic [STEP_W-1:0]        step_size,
    input  logic [LIM_W-1:0]         max_distance,
    input  logic [IDX_W-1:0]         tile_col,
    input  logic [IDX_W-1:0]         tile_row,
    input  logic [TILE_W-1:0]        tile_value,
    input  logic [POS_W-1:0]         origin_x,
    input  logic [POS_W-1:0]         origin_y,
    input  logic signed [DIR_W-1:0]  dir_x,
    input  logic signed [DIR_W-1:0]  dir_y,
    output logic                     hit,
    output logic [DIST_W-1:0]        distance,
    output logic [IDX_W-1:0]         hit_col,
    output logic [IDX_W-1:0]         hit_row,
    output logic [TILE_W-1:0]        wall_type,
    output logic                     vertical_side,
    output logic [U_W-1:0]           wall_u,
    output logic                     write_done
);

    localparam int MAP_DEPTH = MAP_WIDTH * MAP_HEIGHT;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);

    // tile map
    logic [TILE_W-1:0] map_mem [MAP_DEPTH];
    logic [TILE_W-1:0] rdata_reg;

    // clearing pass
    logic [MAP_AW-1:0] clr_addr_reg;
    logic [MAP_AW-1:0] clr_addr_next;

    // captured item
    logic [IDX_W-1:0]        col_reg;
    logic [IDX_W-1:0]        row_reg;
    logic [TILE_W-1:0]       val_reg;
    logic [POS_W-1:0]        ox_reg;
    logic [POS_W-1:0]        oy_reg;
    logic signed [DIR_W-1:0] dx_reg;
    logic signed [DIR_W-1:0] dy_reg;

    // march state
    logic [DIST_W-1:0]         d_reg;
    logic signed [DSTEP_W-1:0] dstep_x_reg;
    logic signed [DSTEP_W-1:0] dstep_y_reg;
    logic signed [PROD_W-1:0]  px_reg;
    logic signed [PROD_W-1:0]  py_reg;
    logic signed [CELL_W-1:0]  cx_reg;
    logic signed [CELL_W-1:0]  cy_reg;
    logic signed [CELL_W-1:0]  prev_cx_reg;
    logic [FRAC_W-1:0]         fx_reg;
    logic [FRAC_W-1:0]         fy_reg;
    logic                      inmap_reg;
    logic                      probed_reg;

    // combinational
    logic [STEP_W-1:0]         step_eff;
    logic signed [DSTEP_W-1:0] dstep_x_next;
    logic signed [DSTEP_W-1:0] dstep_y_next;
    logic signed [COORD_W-1:0] tx_probe;
    logic signed [COORD_W-1:0] ty_probe;
    logic signed [CELL_W-1:0]  cx_probe;
    logic signed [CELL_W-1:0]  cy_probe;
    logic                      inmap_probe;
    logic [ADDR_CALC_W-1:0]    rd_addr_full;
    logic [ADDR_CALC_W-1:0]    wr_addr_full;
    logic                      wr_ok;
    logic                      vert;
    logic [FRAC_W-1:0]         frac_sel;
    logic                      mirror;
    logic [U_W-1:0]            u_hit;

    // zero step behaves as one
    assign step_eff = (step_size == '0) ? STEP_W'(1) : step_size;

    assign dstep_x_next = dx_reg * $signed({1'b0, step_eff});
    assign dstep_y_next = dy_reg * $signed({1'b0, step_eff});

    // floor(dir*d / 2^14) is an arithmetic shift of the exact product
    assign tx_probe = $signed({2'b00, ox_reg}) + $signed(px_reg[PROD_W-1:DIR_SH]);
    assign ty_probe = $signed({2'b00, oy_reg}) + $signed(py_reg[PROD_W-1:DIR_SH]);
    assign cx_probe = tx_probe[COORD_W-1:FRAC_W];
    assign cy_probe = ty_probe[COORD_W-1:FRAC_W];

    assign inmap_probe = !cx_probe[CELL_W-1] && !cy_probe[CELL_W-1]
                      && (cx_probe[CELL_W-2:0] < (CELL_W-1)'(MAP_WIDTH))
                      && (cy_probe[CELL_W-2:0] < (CELL_W-1)'(MAP_HEIGHT));

    assign rd_addr_full = {{(IDX_W+1){1'b0}}, cy_probe[IDX_W-1:0]} * ADDR_CALC_W'(MAP_WIDTH)
                        + {{(IDX_W+1){1'b0}}, cx_probe[IDX_W-1:0]};
    assign wr_addr_full = {{(IDX_W+1){1'b0}}, row_reg} * ADDR_CALC_W'(MAP_WIDTH)
                        + {{(IDX_W+1){1'b0}}, col_reg};
    assign wr_ok = ({1'b0, col_reg} < (IDX_W+1)'(MAP_WIDTH))
                && ({1'b0, row_reg} < (IDX_W+1)'(MAP_HEIGHT));

    assign clr_addr_next = status.clear_last ? '0 : clr_addr_reg + MAP_AW'(1);

    // status back to the controller
    assign status.clear_last = (clr_addr_reg == MAP_AW'(MAP_DEPTH - 1));
    assign status.wall       = probed_reg && (!inmap_reg || (rdata_reg != '0));
    assign status.at_limit   = (d_reg >= {1'b0, max_distance});

    // hit geometry
    assign vert     = (prev_cx_reg != cx_reg);
    assign frac_sel = vert ? fy_reg : fx_reg;
    assign mirror   = vert ? dx_reg[DIR_W-1] : dy_reg[DIR_W-1];
    assign u_hit    = mirror ? (U_W'(1) << FRAC_W) - {1'b0, frac_sel} : {1'b0, frac_sel};

    // map storage, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.clear_en) begin
            map_mem[clr_addr_reg] <= '0;
        end else if (cmd.write_en && wr_ok) begin
            map_mem[wr_addr_full[MAP_AW-1:0]] <= val_reg;
        end
        if (cmd.probe_en) begin
            rdata_reg <= map_mem[rd_addr_full[MAP_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            probed_reg   <= 1'b0;
        end else begin
            if (cmd.clear_en) begin
                clr_addr_reg <= clr_addr_next;
            end
            if (cmd.init_en) begin
                probed_reg <= 1'b0;
            end else if (cmd.probe_en) begin
                probed_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture_en) begin
            col_reg <= tile_col;
            row_reg <= tile_row;
            val_reg <= tile_value;
            ox_reg  <= origin_x;
            oy_reg  <= origin_y;
            dx_reg  <= dir_x;
            dy_reg  <= dir_y;
        end
        if (cmd.init_en) begin
            d_reg       <= '0;
            px_reg      <= '0;
            py_reg      <= '0;
            dstep_x_reg <= dstep_x_next;
            dstep_y_reg <= dstep_y_next;
            // the point before the first step is the origin cell
            cx_reg      <= $signed({2'b00, ox_reg[POS_W-1:FRAC_W]});
        end
        if (cmd.step_en) begin
            d_reg  <= d_reg + {{(DIST_W-STEP_W){1'b0}}, step_eff};
            px_reg <= px_reg + {{(PROD_W-DSTEP_W){dstep_x_reg[DSTEP_W-1]}}, dstep_x_reg};
            py_reg <= py_reg + {{(PROD_W-DSTEP_W){dstep_y_reg[DSTEP_W-1]}}, dstep_y_reg};
        end
        if (cmd.probe_en) begin
            prev_cx_reg <= cx_reg;
            cx_reg      <= cx_probe;
            cy_reg      <= cy_probe;
            fx_reg      <= tx_probe[FRAC_W-1:0];
            fy_reg      <= ty_probe[FRAC_W-1:0];
            inmap_reg   <= inmap_probe;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            unique case (cmd.kind)
                RES_WRITE: begin
                    hit           <= 1'b0;
                    distance      <= '0;
                    hit_col       <= '0;
                    hit_row       <= '0;
                    wall_type     <= '0;
                    vertical_side <= 1'b0;
                    wall_u        <= '0;
                    write_done    <= 1'b1;
                end
                RES_HIT: begin
                    hit           <= 1'b1;
                    distance      <= d_reg;
                    hit_col       <= cx_reg[IDX_W-1:0];
                    hit_row       <= cy_reg[IDX_W-1:0];
                    wall_type     <= inmap_reg ? rdata_reg : '0;
                    vertical_side <= vert;
                    wall_u        <= u_hit;
                    write_done    <= 1'b0;
                end
                default: begin
                    hit           <= 1'b0;
                    distance      <= d_reg;
                    hit_col       <= '0;
                    hit_row       <= '0;
                    wall_type     <= '0;
                    vertical_side <= 1'b0;
                    wall_u        <= '0;
                    write_done    <= 1'b0;
                end
            endcase
        end
    end

    `FSRM_ASSERT_IMPL(a_probe_after_step, aclk, aresetn, cmd.probe_en, d_reg != '0)
    `FSRM_ASSERT_NEXT(a_clear_wraps, aclk, aresetn, cmd.clear_en && status.clear_last, clr_addr_reg == '0)

endmodule

// ===== hw/rtl/fsrm_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsrm_ctrl
// sequencer: map clear, tile write, march loop and result hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fixed_step_ray_march_wall_hit_macros.svh"

module fsrm_ctrl
    import fsrm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  item_cmd_t  s_cmd,
    output logic       m_tvalid,
    input  logic       m_tready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.kind   = RES_WRITE;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture_en = 1'b1;
                    state_next     = (s_cmd == CMD_CAST) ? ST_INIT : ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.write_en = 1'b1;
                state_next   = ST_DONE_WRITE;
            end
            ST_INIT: begin
                cmd.init_en = 1'b1;
                state_next  = ST_STEP;
            end
            ST_STEP: begin
                if (status.wall) begin
                    state_next = ST_DONE_HIT;
                end else if (status.at_limit) begin
                    state_next = ST_DONE_MISS;
                end else begin
                    cmd.step_en = 1'b1;
                    state_next  = ST_PROBE;
                end
            end
            ST_PROBE: begin
                cmd.probe_en = 1'b1;
                state_next   = ST_STEP;
            end
            ST_DONE_WRITE, ST_DONE_HIT, ST_DONE_MISS: begin
                cmd.kind = (state_reg == ST_DONE_HIT)  ? RES_HIT :
                           (state_reg == ST_DONE_MISS) ? RES_MISS : RES_WRITE;
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    `FSRM_ASSERT_IMPL(a_load_slot_free, aclk, aresetn, cmd.load_out, out_free)
    `FSRM_ASSERT_IMPL(a_step_only_live, aclk, aresetn, cmd.step_en, !status.wall && !status.at_limit)
    `FSRM_ASSERT_NEXT(a_clear_exit, aclk, aresetn, state_reg == ST_CLEAR && status.clear_last, state_reg == ST_IDLE)

endmodule
